FILE: design/oad_pkg.sv
// ---------------------------------------------------------------------------
// oad_pkg
// Shared constants, codes and types of the obstacle avoidance drive unit.
// ---------------------------------------------------------------------------
package oad_pkg;

    // field widths
    localparam int DIST_W     = 10;
    localparam int SPEED_W    = 8;
    localparam int MS_W       = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // defaults of the structural parameters
    localparam int WINDOW_LEN_DEF  = 5;
    localparam int QUEUE_DEPTH_DEF = 2;

    // fixed behavior constants
    localparam int WAIT_MS          = 300;
    localparam int SIDE_NEAR_CM     = 9;
    localparam int ROTATE_MARGIN_CM = 5;
    localparam int NUM_SENSORS      = 3;
    localparam int SENSOR_LEFT      = 0;
    localparam int SENSOR_RIGHT     = 1;
    localparam int SENSOR_CENTER    = 2;

    // drive phase
    typedef enum logic [2:0] {
        PH_DECIDE  = 3'd0,
        PH_FAST    = 3'd1,
        PH_SLOW    = 3'd2,
        PH_REVERSE = 3'd3,
        PH_ROTATE  = 3'd4,
        PH_WAIT    = 3'd5
    } phase_t;

    // motor direction
    typedef enum logic [2:0] {
        DIR_HALT     = 3'd0,
        DIR_FWD      = 3'd1,
        DIR_BACK     = 3'd2,
        DIR_TO_LEFT  = 3'd3,
        DIR_TO_RIGHT = 3'd4
    } dir_t;

    // drive command
    typedef enum logic [1:0] {
        CMD_NONE      = 2'd0,
        CMD_SET       = 2'd1,
        CMD_ROT_LEFT  = 2'd2,
        CMD_ROT_RIGHT = 2'd3
    } cmd_t;

    // configuration register index
    typedef enum logic [2:0] {
        REG_FAST_ENTER = 3'd0,
        REG_SLOW_ENTER = 3'd1,
        REG_FAST_EXIT  = 3'd2,
        REG_SLOW_EXIT  = 3'd3,
        REG_MAX_SPEED  = 3'd4,
        REG_MIN_SPEED  = 3'd5,
        REG_REVERSE_MS = 3'd6,
        REG_ROTATE_MS  = 3'd7
    } cfg_idx_t;

    // front-end sequencer
    typedef enum logic [1:0] {
        FR_IDLE = 2'd0,
        FR_SCAN = 2'd1,
        FR_PUSH = 2'd2
    } front_state_t;

    // configuration bundle
    typedef struct packed {
        logic [DIST_W-1:0]  fast_enter_cm;
        logic [DIST_W-1:0]  slow_enter_cm;
        logic [DIST_W-1:0]  fast_exit_cm;
        logic [DIST_W-1:0]  slow_exit_cm;
        logic [SPEED_W-1:0] max_speed;
        logic [SPEED_W-1:0] min_speed;
        logic [MS_W-1:0]    reverse_ms;
        logic [MS_W-1:0]    rotate_ms;
    } cfg_t;

    // filtered item handed from front to back
    typedef struct packed {
        logic [DIST_W-1:0] dist_left;
        logic [DIST_W-1:0] dist_right;
        logic [DIST_W-1:0] dist_center;
        logic [TIME_W-1:0] now_ms;
    } med_item_t;

endpackage

FILE: design/obstacle_avoid_drive_fsm_unit.sv
// ---------------------------------------------------------------------------
// obstacle_avoid_drive_fsm_unit
// Median-filtered ultrasonic obstacle avoidance drive controller.
// ---------------------------------------------------------------------------
// Each transaction on the s_ channel brings left, right and center distances
// and a millisecond time stamp, and yields exactly one m_ transaction with the
// drive command, the held motor settings and the phase after the step. The
// front end shifts the sample into the windows when it takes a transaction,
// runs a rank scan over the window entries, one at a time, for the three
// medians, and hands the result to the queue, taking no new transaction
// before that. The phase machine works from a queue of QUEUE_DEPTH entries
// (two by default), so a slow m_ready consumer holds off the front end
// only once the queue is full. Thresholds, speeds and phase times are set
// through the APB port, one register per 4-byte word, and should only be
// changed while no transaction is in flight.
module obstacle_avoid_drive_fsm_unit #(
    parameter int WINDOW_LEN  = oad_pkg::WINDOW_LEN_DEF,
    parameter int QUEUE_DEPTH = oad_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // sensor channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [oad_pkg::DIST_W-1:0]       s_dist_left,
    input  logic [oad_pkg::DIST_W-1:0]       s_dist_right,
    input  logic [oad_pkg::DIST_W-1:0]       s_dist_center,
    input  logic [oad_pkg::TIME_W-1:0]       s_now_ms,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_command,
    output logic [2:0]                       m_front_dir,
    output logic [2:0]                       m_side_dir,
    output logic [oad_pkg::SPEED_W-1:0]      m_drive_speed,
    output logic [oad_pkg::SPEED_W-1:0]      m_steer_speed,
    output logic [2:0]                       m_machine_state,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [oad_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [oad_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [oad_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    oad_pkg::cfg_t      cfg;
    oad_pkg::med_item_t push_item;
    oad_pkg::med_item_t pop_item;
    logic               push_valid;
    logic               push_ready;
    logic               pop_valid;
    logic               pop_en;

    // configuration registers
    oad_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // windowing and median front end
    oad_front #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_dist_left   (s_dist_left),
        .s_dist_right  (s_dist_right),
        .s_dist_center (s_dist_center),
        .s_now_ms      (s_now_ms),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    // decoupling queue
    oad_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_en     (pop_en),
        .pop_item   (pop_item)
    );

    // drive phase machine
    oad_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .q_valid         (pop_valid),
        .q_pop           (pop_en),
        .q_item          (pop_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_command       (m_command),
        .m_front_dir     (m_front_dir),
        .m_side_dir      (m_side_dir),
        .m_drive_speed   (m_drive_speed),
        .m_steer_speed   (m_steer_speed),
        .m_machine_state (m_machine_state)
    );

endmodule

FILE: design/oad_cfg.sv
// ---------------------------------------------------------------------------
// oad_cfg
// APB-style configuration register file with reset defaults.
// ---------------------------------------------------------------------------
module oad_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [oad_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [oad_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [oad_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output oad_pkg::cfg_t                    cfg
);

    oad_pkg::cfg_t     cfg_reg;
    oad_pkg::cfg_idx_t reg_idx;
    logic              wr_en;

    assign reg_idx = oad_pkg::cfg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fast_enter_cm <= oad_pkg::DIST_W'(40);
            cfg_reg.slow_enter_cm <= oad_pkg::DIST_W'(20);
            cfg_reg.fast_exit_cm  <= oad_pkg::DIST_W'(30);
            cfg_reg.slow_exit_cm  <= oad_pkg::DIST_W'(15);
            cfg_reg.max_speed     <= oad_pkg::SPEED_W'(200);
            cfg_reg.min_speed     <= oad_pkg::SPEED_W'(100);
            cfg_reg.reverse_ms    <= oad_pkg::MS_W'(500);
            cfg_reg.rotate_ms     <= oad_pkg::MS_W'(500);
        end else if (wr_en) begin
            unique case (reg_idx)
                oad_pkg::REG_FAST_ENTER: cfg_reg.fast_enter_cm <= pwdata[oad_pkg::DIST_W-1:0];
                oad_pkg::REG_SLOW_ENTER: cfg_reg.slow_enter_cm <= pwdata[oad_pkg::DIST_W-1:0];
                oad_pkg::REG_FAST_EXIT:  cfg_reg.fast_exit_cm  <= pwdata[oad_pkg::DIST_W-1:0];
                oad_pkg::REG_SLOW_EXIT:  cfg_reg.slow_exit_cm  <= pwdata[oad_pkg::DIST_W-1:0];
                oad_pkg::REG_MAX_SPEED:  cfg_reg.max_speed     <= pwdata[oad_pkg::SPEED_W-1:0];
                oad_pkg::REG_MIN_SPEED:  cfg_reg.min_speed     <= pwdata[oad_pkg::SPEED_W-1:0];
                oad_pkg::REG_REVERSE_MS: cfg_reg.reverse_ms    <= pwdata[oad_pkg::MS_W-1:0];
                oad_pkg::REG_ROTATE_MS:  cfg_reg.rotate_ms     <= pwdata[oad_pkg::MS_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            oad_pkg::REG_FAST_ENTER: prdata = oad_pkg::CFG_DATA_W'(cfg_reg.fast_enter_cm);
            oad_pkg::REG_SLOW_ENTER: prdata = oad_pkg::CFG_DATA_W'(cfg_reg.slow_enter_cm);
            oad_pkg::REG_FAST_EXIT:  prdata = oad_pkg::CFG_DATA_W'(cfg_reg.fast_exit_cm);
            oad_pkg::REG_SLOW_EXIT:  prdata = oad_pkg::CFG_DATA_W'(cfg_reg.slow_exit_cm);
            oad_pkg::REG_MAX_SPEED:  prdata = oad_pkg::CFG_DATA_W'(cfg_reg.max_speed);
            oad_pkg::REG_MIN_SPEED:  prdata = oad_pkg::CFG_DATA_W'(cfg_reg.min_speed);
            oad_pkg::REG_REVERSE_MS: prdata = oad_pkg::CFG_DATA_W'(cfg_reg.reverse_ms);
            oad_pkg::REG_ROTATE_MS:  prdata = oad_pkg::CFG_DATA_W'(cfg_reg.rotate_ms);
            default:                 prdata = '0;
        endcase
    end

endmodule

FILE: design/oad_front.sv
// ---------------------------------------------------------------------------
// oad_front
// Accepts sensor transactions, keeps the sliding windows and finds the
// median of each window by a rank scan, one candidate per cycle.
// ---------------------------------------------------------------------------
module oad_front #(
    parameter int WINDOW_LEN = oad_pkg::WINDOW_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [oad_pkg::DIST_W-1:0]    s_dist_left,
    input  logic [oad_pkg::DIST_W-1:0]    s_dist_right,
    input  logic [oad_pkg::DIST_W-1:0]    s_dist_center,
    input  logic [oad_pkg::TIME_W-1:0]    s_now_ms,
    output logic                          push_valid,
    input  logic                          push_ready,
    output oad_pkg::med_item_t            push_item
);

    localparam int IDX_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
    localparam int MED_POS = WINDOW_LEN / 2;

    oad_pkg::front_state_t state_reg, state_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [oad_pkg::TIME_W-1:0]  now_reg;
    logic [oad_pkg::DIST_W-1:0]  win_reg [oad_pkg::NUM_SENSORS][WINDOW_LEN];
    logic [oad_pkg::DIST_W-1:0]  med_reg [oad_pkg::NUM_SENSORS];
    logic [oad_pkg::DIST_W-1:0]  new_dist [oad_pkg::NUM_SENSORS];
    logic [oad_pkg::DIST_W-1:0]  cand [oad_pkg::NUM_SENSORS];
    logic [oad_pkg::NUM_SENSORS-1:0] hit;
    logic                        accept;
    logic                        scan_last;

    assign new_dist[oad_pkg::SENSOR_LEFT]   = s_dist_left;
    assign new_dist[oad_pkg::SENSOR_RIGHT]  = s_dist_right;
    assign new_dist[oad_pkg::SENSOR_CENTER] = s_dist_center;

    assign s_ready   = (state_reg == oad_pkg::FR_IDLE);
    assign accept    = s_valid && s_ready;
    assign scan_last = (idx_reg == IDX_W'(WINDOW_LEN - 1));

    // rank test of the current candidate in each window
    for (genvar s = 0; s < oad_pkg::NUM_SENSORS; s++) begin : g_rank
        logic [CNT_W-1:0] lt_cnt;
        logic [CNT_W-1:0] le_cnt;

        assign cand[s] = win_reg[s][idx_reg];

        always_comb begin
            lt_cnt = '0;
            le_cnt = '0;
            for (int j = 0; j < WINDOW_LEN; j++) begin
                if (win_reg[s][j] < cand[s]) lt_cnt = lt_cnt + CNT_W'(1);
                if (win_reg[s][j] <= cand[s]) le_cnt = le_cnt + CNT_W'(1);
            end
        end

        assign hit[s] = (lt_cnt <= CNT_W'(MED_POS)) && (le_cnt > CNT_W'(MED_POS));
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            oad_pkg::FR_IDLE: begin
                if (accept) begin
                    state_next = oad_pkg::FR_SCAN;
                    idx_next   = '0;
                end
            end
            oad_pkg::FR_SCAN: begin
                if (scan_last) begin
                    state_next = oad_pkg::FR_PUSH;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            oad_pkg::FR_PUSH: begin
                if (push_ready) state_next = oad_pkg::FR_IDLE;
            end
            default: state_next = oad_pkg::FR_IDLE;
        endcase
    end

    // sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= oad_pkg::FR_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // windows shift in the new sample, oldest drops out
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < oad_pkg::NUM_SENSORS; s++) begin
                for (int j = 0; j < WINDOW_LEN; j++) win_reg[s][j] <= '0;
            end
        end else if (accept) begin
            for (int s = 0; s < oad_pkg::NUM_SENSORS; s++) begin
                win_reg[s][0] <= new_dist[s];
                for (int j = 1; j < WINDOW_LEN; j++) win_reg[s][j] <= win_reg[s][j-1];
            end
        end
    end

    // time stamp and median capture
    always_ff @(posedge aclk) begin
        if (accept) now_reg <= s_now_ms;
        if (state_reg == oad_pkg::FR_SCAN) begin
            for (int s = 0; s < oad_pkg::NUM_SENSORS; s++) begin
                if (hit[s]) med_reg[s] <= cand[s];
            end
        end
    end

    assign push_valid            = (state_reg == oad_pkg::FR_PUSH);
    assign push_item.dist_left   = med_reg[oad_pkg::SENSOR_LEFT];
    assign push_item.dist_right  = med_reg[oad_pkg::SENSOR_RIGHT];
    assign push_item.dist_center = med_reg[oad_pkg::SENSOR_CENTER];
    assign push_item.now_ms      = now_reg;

endmodule

FILE: design/oad_queue.sv
// ---------------------------------------------------------------------------
// oad_queue
// Short first-in first-out queue of filtered items between front and back.
// ---------------------------------------------------------------------------
module oad_queue #(
    parameter int DEPTH = oad_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  oad_pkg::med_item_t  push_item,
    output logic                pop_valid,
    input  logic                pop_en,
    output oad_pkg::med_item_t  pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    oad_pkg::med_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_en && pop_valid;
    assign pop_item   = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_item;
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

FILE: design/oad_back.sv
// ---------------------------------------------------------------------------
// oad_back
// Drive phase machine: takes one filtered item per step, updates the held
// motor settings and presents the result in an output register.
// ---------------------------------------------------------------------------
module oad_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  oad_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  oad_pkg::med_item_t            q_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_command,
    output logic [2:0]                    m_front_dir,
    output logic [2:0]                    m_side_dir,
    output logic [oad_pkg::SPEED_W-1:0]   m_drive_speed,
    output logic [oad_pkg::SPEED_W-1:0]   m_steer_speed,
    output logic [2:0]                    m_machine_state
);

    oad_pkg::phase_t             phase_reg, phase_next;
    oad_pkg::cmd_t               cmd_reg, cmd_next;
    oad_pkg::dir_t               front_dir_reg, front_dir_next;
    oad_pkg::dir_t               side_dir_reg, side_dir_next;
    logic [oad_pkg::SPEED_W-1:0] drive_speed_reg, drive_speed_next;
    logic [oad_pkg::SPEED_W-1:0] steer_speed_reg, steer_speed_next;
    logic [oad_pkg::TIME_W-1:0]  start_ms_reg, start_ms_next;
    logic                        m_valid_reg, m_valid_next;

    logic [oad_pkg::TIME_W-1:0]  elapsed;
    logic                        is_fast;
    logic [oad_pkg::SPEED_W-1:0] fwd_speed;
    logic [oad_pkg::DIST_W-1:0]  exit_cm;
    logic [oad_pkg::DIST_W:0]    right_margin;

    // output register frees up when the result is taken
    assign q_pop = q_valid && (!m_valid_reg || m_ready);

    assign elapsed      = q_item.now_ms - start_ms_reg;
    assign is_fast      = (phase_reg == oad_pkg::PH_FAST);
    assign fwd_speed    = is_fast ? cfg.max_speed : cfg.min_speed;
    assign exit_cm      = is_fast ? cfg.fast_exit_cm : cfg.slow_exit_cm;
    assign right_margin = {1'b0, q_item.dist_right}
                        + (oad_pkg::DIST_W + 1)'(oad_pkg::ROTATE_MARGIN_CM);

    // phase step
    always_comb begin
        phase_next       = phase_reg;
        cmd_next         = cmd_reg;
        front_dir_next   = front_dir_reg;
        side_dir_next    = side_dir_reg;
        drive_speed_next = drive_speed_reg;
        steer_speed_next = steer_speed_reg;
        start_ms_next    = start_ms_reg;
        m_valid_next     = m_valid_reg;

        if (m_ready) m_valid_next = 1'b0;

        if (q_pop) begin
            m_valid_next = 1'b1;
            cmd_next     = oad_pkg::CMD_NONE;
            unique case (phase_reg)
                oad_pkg::PH_DECIDE: begin
                    if (q_item.dist_center > cfg.fast_enter_cm) begin
                        phase_next = oad_pkg::PH_FAST;
                    end else if (q_item.dist_center > cfg.slow_enter_cm) begin
                        phase_next = oad_pkg::PH_SLOW;
                    end else begin
                        phase_next    = oad_pkg::PH_REVERSE;
                        start_ms_next = q_item.now_ms;
                    end
                end
                oad_pkg::PH_FAST, oad_pkg::PH_SLOW: begin
                    front_dir_next   = oad_pkg::DIR_FWD;
                    drive_speed_next = fwd_speed;
                    if (q_item.dist_right < oad_pkg::DIST_W'(oad_pkg::SIDE_NEAR_CM)) begin
                        side_dir_next    = oad_pkg::DIR_TO_LEFT;
                        steer_speed_next = fwd_speed >> 1;
                    end else if (q_item.dist_left < oad_pkg::DIST_W'(oad_pkg::SIDE_NEAR_CM)) begin
                        side_dir_next    = oad_pkg::DIR_TO_RIGHT;
                        steer_speed_next = fwd_speed >> 1;
                    end else begin
                        side_dir_next    = oad_pkg::DIR_FWD;
                        steer_speed_next = fwd_speed;
                    end
                    cmd_next = oad_pkg::CMD_SET;
                    if (q_item.dist_center <= exit_cm) phase_next = oad_pkg::PH_DECIDE;
                end
                oad_pkg::PH_REVERSE: begin
                    if (elapsed < oad_pkg::TIME_W'(cfg.reverse_ms)) begin
                        front_dir_next   = oad_pkg::DIR_BACK;
                        side_dir_next    = oad_pkg::DIR_BACK;
                        drive_speed_next = cfg.min_speed;
                        steer_speed_next = cfg.min_speed;
                        cmd_next         = oad_pkg::CMD_SET;
                    end else begin
                        phase_next    = oad_pkg::PH_ROTATE;
                        start_ms_next = q_item.now_ms;
                    end
                end
                oad_pkg::PH_ROTATE: begin
                    if (elapsed < oad_pkg::TIME_W'(cfg.rotate_ms)) begin
                        drive_speed_next = cfg.min_speed;
                        steer_speed_next = cfg.min_speed;
                        cmd_next = (right_margin > {1'b0, q_item.dist_left})
                                 ? oad_pkg::CMD_ROT_LEFT : oad_pkg::CMD_ROT_RIGHT;
                    end else begin
                        phase_next       = oad_pkg::PH_WAIT;
                        start_ms_next    = q_item.now_ms;
                        front_dir_next   = oad_pkg::DIR_HALT;
                        side_dir_next    = oad_pkg::DIR_HALT;
                        drive_speed_next = '0;
                        steer_speed_next = '0;
                        cmd_next         = oad_pkg::CMD_SET;
                    end
                end
                oad_pkg::PH_WAIT: begin
                    if (elapsed >= oad_pkg::TIME_W'(oad_pkg::WAIT_MS)) begin
                        phase_next = oad_pkg::PH_DECIDE;
                    end
                end
                default: phase_next = oad_pkg::PH_DECIDE;
            endcase
        end
    end

    // phase and held motor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= oad_pkg::PH_FAST;
            cmd_reg         <= oad_pkg::CMD_NONE;
            front_dir_reg   <= oad_pkg::DIR_HALT;
            side_dir_reg    <= oad_pkg::DIR_HALT;
            drive_speed_reg <= '0;
            steer_speed_reg <= '0;
            start_ms_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            cmd_reg         <= cmd_next;
            front_dir_reg   <= front_dir_next;
            side_dir_reg    <= side_dir_next;
            drive_speed_reg <= drive_speed_next;
            steer_speed_reg <= steer_speed_next;
            start_ms_reg    <= start_ms_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // held state is the result while it waits to be taken
    assign m_valid         = m_valid_reg;
    assign m_command       = cmd_reg;
    assign m_front_dir     = front_dir_reg;
    assign m_side_dir      = side_dir_reg;
    assign m_drive_speed   = drive_speed_reg;
    assign m_steer_speed   = steer_speed_reg;
    assign m_machine_state = phase_reg;

endmodule
